// File: hdl/canms_pkg.sv
// shared types and constants for the class aware nms core
// no dependencies
package canms_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam logic [15:0] CONF_RESET = 16'd16384;
    localparam logic [15:0] IOU_RESET = 16'd29491;
    localparam logic CFG_CONF = 1'b0;
    localparam logic CFG_IOU = 1'b1;

    typedef struct packed {
        logic valid;
        logic supp;
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
        logic [15:0] score;
        logic [7:0] cls;
    } box_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        box_t new_box;
    } cell_ctrl_t;

endpackage

// File: hdl/canms_cell.sv
// one storage cell of the sorted box chain
// depends on canms_pkg
module canms_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  canms_pkg::cell_ctrl_t ctrl,
    input  canms_pkg::box_t       left_box,
    input  logic                  left_ge,
    input  canms_pkg::box_t       right_box,
    output canms_pkg::box_t       box,
    output logic                  ge
);

    canms_pkg::box_t box_reg;
    canms_pkg::box_t box_next;
    logic valid_reg;
    logic valid_next;

    always_comb
    begin
        box = box_reg;
        box.valid = valid_reg;
    end

    assign ge = valid_reg && (box_reg.score >= ctrl.new_box.score);

    always_comb
    begin
        box_next = box;
        case (ctrl.op)
            canms_pkg::OP_INSERT:
            begin
                if (!ge)
                begin
                    if (!left_ge)
                        box_next = left_box;
                    else
                        box_next = ctrl.new_box;
                end
            end
            canms_pkg::OP_ROTATE: box_next = right_box;
            canms_pkg::OP_CLEAR:
            begin
                box_next.valid = 1'b0;
                box_next.supp = 1'b0;
            end
            default: box_next = box;
        endcase
        valid_next = box_next.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

endmodule

// File: hdl/canms_iou.sv
// four stage overlap test of one box against the reference box
// depends on canms_pkg
module canms_iou
(
    input  logic            clk,
    input  canms_pkg::box_t ref_box,
    input  logic [31:0]     ref_area,
    input  canms_pkg::box_t cand,
    input  logic [15:0]     iou_thr,
    output logic            hit
);

    logic signed [15:0] xx1, yy1, xx2, yy2, rj0, bj0;
    logic signed [16:0] dw, dh;
    logic [15:0] w_reg, h_reg, wj_reg, hj_reg;
    logic [31:0] inter_reg, areaj_reg;
    logic [31:0] inter2_reg;
    logic signed [33:0] uni_reg;
    logic signed [50:0] lhs, rhs;
    logic hit_reg;

    always_comb
    begin
        xx1 = (cand.l > ref_box.l) ? cand.l : ref_box.l;
        yy1 = (cand.t > ref_box.t) ? cand.t : ref_box.t;
        rj0 = (cand.r > 16'sd0) ? cand.r : 16'sd0;
        bj0 = (cand.b > 16'sd0) ? cand.b : 16'sd0;
        xx2 = (rj0 < ref_box.r) ? rj0 : ref_box.r;
        yy2 = (bj0 < ref_box.b) ? bj0 : ref_box.b;
        dw = 17'(xx2) - 17'(xx1);
        dh = 17'(yy2) - 17'(yy1);
        lhs = 51'($signed({1'b0, inter2_reg, 16'h0000}));
        rhs = $signed({35'h0, iou_thr}) * 51'(uni_reg);
    end

    always_ff @(posedge clk)
    begin
        w_reg <= dw[16] ? 16'h0000 : dw[15:0];
        h_reg <= dh[16] ? 16'h0000 : dh[15:0];
        wj_reg <= 16'(17'(cand.r) - 17'(cand.l));
        hj_reg <= 16'(17'(cand.b) - 17'(cand.t));
        inter_reg <= w_reg * h_reg;
        areaj_reg <= wj_reg * hj_reg;
        inter2_reg <= inter_reg;
        uni_reg <= 34'(ref_area) + 34'(areaj_reg) - 34'(inter_reg);
        hit_reg <= (uni_reg <= 34'sd0) || (lhs > rhs);
    end

    assign hit = hit_reg;

endmodule

// File: hdl/class_aware_nms_core.sv
// top level of the class aware nms core: filter stage, cell chain, suppression sequencer
// depends on canms_pkg, canms_cell, canms_iou
//
// channel | direction | handshake           | payload
// cand    | in        | cand_valid/stall    | center_x .. last_candidate
// res     | out       | res_valid/stall     | left .. last_result
// cfg     | in        | cfg_valid/ready     | cfg_index, cfg_data
//
// candidates enter one per cycle unless stalled, each inserted in the cycle after
// suppression rotates the chain once per pass: MAX_BOXES passes of MAX_BOXES+1 steps,
// each same-class compare waits in S_CMP_A to S_CMP_D for the overlap unit
// emission then sends the kept boxes, waiting on result stalls, and S_CLEAR follows
// cand_stall is high from the last candidate until the chain is cleared
// reset clears the chain valid bits and sets the thresholds to their reset values
module class_aware_nms_core
#(
    parameter int MAX_BOXES = canms_pkg::MAX_BOXES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cand_valid,
    output logic               cand_stall,
    input  logic signed [15:0] center_x,
    input  logic signed [15:0] center_y,
    input  logic [14:0]        box_width,
    input  logic [14:0]        box_height,
    input  logic [15:0]        objectness,
    input  logic [15:0]        class_score,
    input  logic [7:0]         class_index,
    input  logic               last_candidate,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [15:0] left,
    output logic signed [15:0] top,
    output logic signed [15:0] right,
    output logic signed [15:0] bottom,
    output logic [15:0]        final_score,
    output logic [7:0]         class_out,
    output logic               no_detections,
    output logic               last_result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int PW = $clog2(MAX_BOXES);
    localparam int SW = $clog2(MAX_BOXES + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_CAPTURE, S_SCAN, S_CMP_A, S_CMP_B, S_CMP_C, S_CMP_D, S_EMIT, S_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic [PW-1:0] pass_reg, pass_next;
    logic [SW-1:0] step_reg, step_next;
    logic [15:0] conf_reg, iou_reg;
    logic stg_ins_reg, stg_last_reg;
    canms_pkg::box_t stg_box_reg;
    canms_pkg::box_t ref_box_reg;
    logic ref_on_reg, ref_on_next;
    logic [31:0] ref_area_reg;
    logic emitted_reg, emitted_next;
    logic res_valid_reg, res_valid_next;
    canms_pkg::box_t res_box_reg, res_box_next;
    logic res_none_reg, res_none_next, res_last_reg, res_last_next;

    canms_pkg::box_t boxes [MAX_BOXES];
    logic [MAX_BOXES-1:0] ges, kept;
    canms_pkg::box_t cell0_mod;
    canms_pkg::cell_ctrl_t ctrl;
    canms_pkg::cell_op_t op;
    logic hit, cand_acc, pass_filter, eligible, res_free, set_supp, drop0;
    logic [31:0] prod;
    logic [15:0] score_in;
    logic [SW:0] rank;
    canms_pkg::box_t in_box;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767)
            return 16'sh7fff;
        else if (v < -17'sd32768)
            return -16'sh8000;
        else
            return v[15:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign cand_stall = (state_reg != S_LOAD) || stg_last_reg;
    assign cand_acc = cand_valid && !cand_stall;

    always_comb
    begin
        prod = objectness * class_score;
        score_in = prod[31:16];
        pass_filter = (objectness > conf_reg) && (score_in > conf_reg);
        in_box.valid = 1'b1;
        in_box.supp = 1'b0;
        in_box.l = sat16(17'(center_x) - 17'(box_width[14:1]));
        in_box.t = sat16(17'(center_y) - 17'(box_height[14:1]));
        in_box.r = sat16(17'(center_x) + 17'(box_width[14:1]));
        in_box.b = sat16(17'(center_y) + 17'(box_height[14:1]));
        in_box.score = score_in;
        in_box.cls = class_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_reg <= canms_pkg::CONF_RESET;
            iou_reg <= canms_pkg::IOU_RESET;
            stg_ins_reg <= 1'b0;
            stg_last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == canms_pkg::CFG_CONF)
                conf_reg <= cfg_data;
            if (cfg_valid && cfg_index == canms_pkg::CFG_IOU)
                iou_reg <= cfg_data;
            stg_ins_reg <= cand_acc && pass_filter;
            stg_last_reg <= cand_acc && last_candidate;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_acc)
            stg_box_reg <= in_box;
    end

    for (genvar k = 0; k < MAX_BOXES; k++)
    begin : g_cell
        canms_pkg::box_t lb, rb;
        logic lg;
        if (k == 0)
        begin : g_first
            assign lb = '0;
            assign lg = 1'b1;
        end
        else
        begin : g_mid
            assign lb = boxes[k-1];
            assign lg = ges[k-1];
        end
        if (k == MAX_BOXES - 1)
        begin : g_last
            assign rb = cell0_mod;
        end
        else
        begin : g_next
            assign rb = boxes[k+1];
        end
        assign kept[k] = boxes[k].valid && !boxes[k].supp;
        canms_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left_box  (lb),
            .left_ge   (lg),
            .right_box (rb),
            .box       (boxes[k]),
            .ge        (ges[k])
        );
    end

    canms_iou u_iou
    (
        .clk      (clk),
        .ref_box  (ref_box_reg),
        .ref_area (ref_area_reg),
        .cand     (boxes[0]),
        .iou_thr  (iou_reg),
        .hit      (hit)
    );

    always_comb
    begin
        rank = (SW+1)'(pass_reg) + (SW+1)'(step_reg);
        eligible = ref_on_reg && (rank < (SW+1)'(MAX_BOXES)) && kept[0]
                   && (boxes[0].cls == ref_box_reg.cls);
        res_free = !res_valid_reg || !res_stall;
        state_next = state_reg;
        pass_next = pass_reg;
        step_next = step_reg;
        ref_on_next = ref_on_reg;
        emitted_next = emitted_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_box_next = res_box_reg;
        res_none_next = res_none_reg;
        res_last_next = res_last_reg;
        op = canms_pkg::OP_HOLD;
        set_supp = 1'b0;
        drop0 = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (stg_ins_reg)
                    op = canms_pkg::OP_INSERT;
                if (stg_last_reg)
                begin
                    state_next = S_CAPTURE;
                    pass_next = '0;
                    step_next = '0;
                end
            end
            S_CAPTURE:
            begin
                op = canms_pkg::OP_ROTATE;
                ref_on_next = kept[0];
                step_next = SW'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (eligible)
                    state_next = S_CMP_A;
                else
                begin
                    op = canms_pkg::OP_ROTATE;
                    step_next = step_reg + SW'(1);
                    if (step_reg == SW'(MAX_BOXES))
                    begin
                        step_next = '0;
                        if (pass_reg == PW'(MAX_BOXES - 1))
                        begin
                            state_next = S_EMIT;
                            emitted_next = 1'b0;
                        end
                        else
                        begin
                            pass_next = pass_reg + PW'(1);
                            state_next = S_CAPTURE;
                        end
                    end
                end
            end
            S_CMP_A: state_next = S_CMP_B;
            S_CMP_B: state_next = S_CMP_C;
            S_CMP_C: state_next = S_CMP_D;
            S_CMP_D:
            begin
                op = canms_pkg::OP_ROTATE;
                set_supp = hit;
                step_next = step_reg + SW'(1);
                state_next = S_SCAN;
            end
            S_EMIT:
            begin
                if (|kept)
                begin
                    if (!kept[0])
                        op = canms_pkg::OP_ROTATE;
                    else if (res_free)
                    begin
                        op = canms_pkg::OP_ROTATE;
                        drop0 = 1'b1;
                        res_valid_next = 1'b1;
                        res_box_next = boxes[0];
                        res_none_next = 1'b0;
                        res_last_next = !(|kept[MAX_BOXES-1:1]);
                        emitted_next = 1'b1;
                    end
                end
                else if (emitted_reg)
                    state_next = S_CLEAR;
                else if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_box_next = '0;
                    res_none_next = 1'b1;
                    res_last_next = 1'b1;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                op = canms_pkg::OP_CLEAR;
                state_next = S_LOAD;
            end
            default: state_next = S_LOAD;
        endcase
        cell0_mod = boxes[0];
        if (set_supp)
            cell0_mod.supp = 1'b1;
        if (drop0)
            cell0_mod.valid = 1'b0;
        ctrl.op = op;
        ctrl.new_box = stg_box_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pass_reg <= '0;
            step_reg <= '0;
            ref_on_reg <= 1'b0;
            emitted_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_box_reg <= '0;
            res_none_reg <= 1'b0;
            res_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg <= pass_next;
            step_reg <= step_next;
            ref_on_reg <= ref_on_next;
            emitted_reg <= emitted_next;
            res_valid_reg <= res_valid_next;
            res_box_reg <= res_box_next;
            res_none_reg <= res_none_next;
            res_last_reg <= res_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CAPTURE)
        begin
            ref_box_reg <= boxes[0];
            ref_area_reg <= 16'(17'(boxes[0].r) - 17'(boxes[0].l))
                            * 16'(17'(boxes[0].b) - 17'(boxes[0].t));
        end
    end

    assign res_valid = res_valid_reg;
    assign left = res_box_reg.l;
    assign top = res_box_reg.t;
    assign right = res_box_reg.r;
    assign bottom = res_box_reg.b;
    assign final_score = res_box_reg.score;
    assign class_out = res_box_reg.cls;
    assign no_detections = res_none_reg;
    assign last_result = res_last_reg;

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && no_detections |-> last_result && final_score == 16'h0000)
        else $error("empty item not marked last");

    a_cmp_ref: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP_D |-> ref_on_reg && $stable(boxes[0]))
        else $error("compare without live reference");

    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_LOAD |-> !stg_ins_reg)
        else $error("insert pending outside load");

endmodule

// File: sim/testbench.sv
// self-checking testbench for class_aware_nms_core: directed and random candidate images, scored boxes, nms check
// depends on canms_pkg and class_aware_nms_core
`timescale 1ns / 100ps

module testbench;

    localparam int NBOX = 64;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0] w;
        logic [14:0] h;
        logic [15:0] obj;
        logic [15:0] cs;
        logic [7:0] cls;
        logic last;
    } cand_t;

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
        logic [15:0] score;
        logic [7:0] cls;
        logic empty;
        logic last;
    } det_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cand_valid = 1'b0;
    logic cand_stall;
    logic signed [15:0] center_x = '0;
    logic signed [15:0] center_y = '0;
    logic [14:0] box_width = '0;
    logic [14:0] box_height = '0;
    logic [15:0] objectness = '0;
    logic [15:0] class_score = '0;
    logic [7:0] class_index = '0;
    logic last_candidate = 1'b0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic signed [15:0] left, top, right, bottom;
    logic [15:0] final_score;
    logic [7:0] class_out;
    logic no_detections, last_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = canms_pkg::CFG_CONF;
    logic [15:0] cfg_data = '0;

    cand_t pending_cands[$];
    det_t expected_dets[$];
    int errors = 0;
    logic [15:0] conf_thr = canms_pkg::CONF_RESET;
    logic [15:0] iou_thr = canms_pkg::IOU_RESET;
    det_t sorted_boxes[NBOX];
    int box_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_off = 0;
    logic long_hold_req = 1'b0;

    class_aware_nms_core i_dut (.*);

    always #5 clk = ~clk;

    function automatic void enqueue_cand(cand_t c);
        pending_cands = {pending_cands, c};
    endfunction

    function automatic void enqueue_det(det_t d);
        expected_dets = {expected_dets, d};
    endfunction

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic bit overlaps(det_t a, det_t b);
        longint xx1, yy1, xx2, yy2, inter, uni;
        xx1 = (b.l > a.l) ? b.l : a.l;
        yy1 = (b.t > a.t) ? b.t : a.t;
        xx2 = (b.r > 0) ? longint'(b.r) : 0;
        if (a.r < xx2) xx2 = a.r;
        yy2 = (b.b > 0) ? longint'(b.b) : 0;
        if (a.b < yy2) yy2 = a.b;
        inter = ((xx2 - xx1) > 0 ? xx2 - xx1 : 0) * ((yy2 - yy1) > 0 ? yy2 - yy1 : 0);
        uni = (longint'(a.r) - a.l) * (longint'(a.b) - a.t)
            + (longint'(b.r) - b.l) * (longint'(b.b) - b.t) - inter;
        if (uni <= 0) return 1'b1;
        return inter * 65536 > longint'(iou_thr) * uni;
    endfunction

    // filter, sorted insert, and at the last item greedy per-class suppression and the expected results
    task automatic predict_detections(cand_t c);
        logic [31:0] prod;
        logic [15:0] score;
        det_t nb;
        int pos, k, hw, hh, kept;
        bit supp[NBOX];
        prod = c.obj * c.cs;
        score = prod[31:16];
        if (c.obj > conf_thr && score > conf_thr)
        begin
            hw = c.w >> 1;
            hh = c.h >> 1;
            nb = '0;
            nb.l = sat16(int'(c.cx) - hw);
            nb.t = sat16(int'(c.cy) - hh);
            nb.r = sat16(int'(c.cx) + hw);
            nb.b = sat16(int'(c.cy) + hh);
            nb.score = score;
            nb.cls = c.cls;
            pos = 0;
            while (pos < box_count && sorted_boxes[pos].score >= score) pos++;
            if (pos < NBOX)
            begin
                k = (box_count < NBOX) ? box_count : NBOX - 1;
                for (; k > pos; k--) sorted_boxes[k] = sorted_boxes[k - 1];
                sorted_boxes[pos] = nb;
                if (box_count < NBOX) box_count++;
            end
        end
        if (!c.last) return;
        for (int i = 0; i < NBOX; i++) supp[i] = 1'b0;
        for (int i = 0; i < box_count; i++)
        begin
            if (supp[i]) continue;
            for (int j = i + 1; j < box_count; j++)
            begin
                if (supp[j] || sorted_boxes[j].cls != sorted_boxes[i].cls) continue;
                if (overlaps(sorted_boxes[i], sorted_boxes[j])) supp[j] = 1'b1;
            end
        end
        kept = 0;
        for (int i = 0; i < box_count; i++)
        begin
            if (supp[i]) continue;
            enqueue_det(sorted_boxes[i]);
            kept++;
        end
        if (kept == 0)
        begin
            nb = '0;
            nb.empty = 1'b1;
            enqueue_det(nb);
        end
        expected_dets[$].last = 1'b1;
        box_count = 0;
    endtask

    // sender: bursts and gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cand_valid && !cand_stall)
            begin
                predict_detections(pending_cands.pop_front());
            end
            if (!(cand_valid && cand_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    cand_valid <= 1'b0;
                end
                else if (pending_cands.size() > 0 && !cfg_valid)
                begin
                    cand_t c;
                    c = pending_cands[0];
                    cand_valid <= 1'b1;
                    center_x <= c.cx;
                    center_y <= c.cy;
                    box_width <= c.w;
                    box_height <= c.h;
                    objectness <= c.obj;
                    class_score <= c.cs;
                    class_index <= c.cls;
                    last_candidate <= c.last;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    cand_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req && hold_off == 0)
            begin
                hold_off <= 20000;
                res_stall <= 1'b1;
            end
            else if (hold_off > 1)
            begin
                hold_off <= hold_off - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                hold_off <= 0;
                res_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_dets.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
            end
            else
            begin
                det_t e;
                e = expected_dets.pop_front();
                if (left !== e.l)
                begin
                    $error("left exp %0d got %0d", e.l, left); errors++;
                end
                if (top !== e.t)
                begin
                    $error("top exp %0d got %0d", e.t, top); errors++;
                end
                if (right !== e.r)
                begin
                    $error("right exp %0d got %0d", e.r, right); errors++;
                end
                if (bottom !== e.b)
                begin
                    $error("bottom exp %0d got %0d", e.b, bottom); errors++;
                end
                if (final_score !== e.score)
                begin
                    $error("final_score exp %0d got %0d", e.score, final_score); errors++;
                end
                if (class_out !== e.cls)
                begin
                    $error("class_out exp %0d got %0d", e.cls, class_out); errors++;
                end
                if (no_detections !== e.empty)
                begin
                    $error("no_detections exp %0d got %0d", e.empty, no_detections); errors++;
                end
                if (last_result !== e.last)
                begin
                    $error("last_result exp %0d got %0d", e.last, last_result); errors++;
                end
            end
        end
    end

    function automatic cand_t rand_cand(int n_cls, bit last);
        cand_t c;
        c.cx = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000)) - 16'sd200;
        c.cy = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000)) - 16'sd200;
        c.w = $urandom_range(0, 9) == 0 ? 15'($urandom) : 15'($urandom_range(0, 800));
        c.h = $urandom_range(0, 9) == 0 ? 15'($urandom) : 15'($urandom_range(0, 800));
        c.obj = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(30000, 65535));
        c.cs = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(30000, 65535));
        c.cls = $urandom_range(0, 15) == 0 ? 8'($urandom) : 8'($urandom_range(0, n_cls - 1));
        c.last = last;
        return c;
    endfunction

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == canms_pkg::CFG_CONF) conf_thr = val;
        else iou_thr = val;
    endtask

    task automatic drain();
        while (pending_cands.size() > 0 || cand_valid || expected_dets.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_image(int n, int n_cls);
        for (int k = 0; k < n; k++) enqueue_cand(rand_cand(n_cls, k == n - 1));
    endtask

    initial
    begin
        cand_t c;
        int sent;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        // directed: extremes, ties, saturation, overlap, empty image
        c = '{16'sh7fff, -16'sh8000, 15'h7fff, 15'h7fff, 16'hffff, 16'hffff, 8'hff, 1'b0};
        enqueue_cand(c);
        c = '{-16'sh8000, 16'sh7fff, 15'h7fff, 15'h7fff, 16'hffff, 16'hffff, 8'h00, 1'b0};
        enqueue_cand(c);
        c = '{16'sd100, 16'sd100, 15'd50, 15'd50, 16'hc000, 16'hc000, 8'd1, 1'b0};
        enqueue_cand(c);
        c = '{16'sd102, 16'sd101, 15'd50, 15'd50, 16'hc000, 16'hc000, 8'd1, 1'b0};
        enqueue_cand(c);
        c = '{16'sd102, 16'sd101, 15'd50, 15'd50, 16'hc000, 16'hc000, 8'd2, 1'b0};
        enqueue_cand(c);
        c = '{-16'sd50, -16'sd50, 15'd20, 15'd20, 16'hf000, 16'hf000, 8'd3, 1'b0};
        enqueue_cand(c);
        c = '{16'sd0, 16'sd0, 15'd0, 15'd0, 16'hf000, 16'hf000, 8'd4, 1'b0};
        enqueue_cand(c);
        c = '{16'sd10, 16'sd10, 15'd1, 15'd3, 16'd16384, 16'hffff, 8'd5, 1'b0};
        enqueue_cand(c);
        c = '{16'sd10, 16'sd10, 15'd1, 15'd3, 16'd0, 16'd0, 8'd5, 1'b1};
        enqueue_cand(c);
        c = '{16'sd10, 16'sd10, 15'd4, 15'd4, 16'd100, 16'hffff, 8'd5, 1'b1};
        enqueue_cand(c);
        drain();
        write_reg(canms_pkg::CFG_CONF, 16'd0);
        write_reg(canms_pkg::CFG_IOU, 16'd0);
        run_image(6, 2);
        drain();
        write_reg(canms_pkg::CFG_CONF, 16'hffff);
        write_reg(canms_pkg::CFG_IOU, 16'hffff);
        run_image(4, 2);
        drain();
        write_reg(canms_pkg::CFG_CONF, 16'd8000);
        write_reg(canms_pkg::CFG_IOU, 16'd20000);
        // full store and overflow, with receiver held off and the next image waiting
        long_hold_req <= 1'b1;
        run_image(80, 3);
        run_image(10, 2);
        sent = 0;
        while (sent < 60)
        begin
            @(posedge clk);
            sent++;
        end
        long_hold_req <= 1'b0;
        drain();
        sent = 0;
        while (sent < 190)
        begin
            int n;
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(canms_pkg::CFG_CONF, 16'($urandom_range(0, 40000)));
                write_reg(canms_pkg::CFG_IOU, 16'($urandom));
            end
            n = $urandom_range(1, 12);
            run_image(n, $urandom_range(1, 4));
            sent += n;
            drain();
        end
        if (errors == 0)
            $display("class_aware_nms_core regression: pass");
        else
            $display("class_aware_nms_core regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("class_aware_nms_core regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/canms_pkg.sv
hdl/canms_cell.sv
hdl/canms_iou.sv
hdl/class_aware_nms_core.sv
sim/testbench.sv
